// ===== design/lev_pkg.sv =====
`timescale 1ns / 1ps

package lev_pkg;

  localparam int MAX_LEN = 32;
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 6;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_D   = MAX_LEN + 1;
  localparam int SAT_W   = (LEN_W > DIST_W) ? LEN_W : DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic MODE_FIRST  = 1'b0;
  localparam logic MODE_SECOND = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             empty_req;
  } lev_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } lev_out_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] n1;
    logic [LEN_W-1:0] n2;
  } seq_ctrl_t;

  typedef struct packed {
    logic             fin;
    logic [LEN_W-1:0] result;
  } seq_stat_t;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_DONE = 3'b100
  } top_state_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_ROW  = 5'b00100,
    S_RD   = 5'b01000,
    S_CMP  = 5'b10000
  } seq_state_e;

endpackage

// ===== design/lev_ram.sv =====
`timescale 1ns / 1ps

module lev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/lev_cell.sv =====
`timescale 1ns / 1ps

module lev_cell (
  input  logic [lev_pkg::LEN_W-1:0] up_i,
  input  logic [lev_pkg::LEN_W-1:0] left_i,
  input  logic [lev_pkg::LEN_W-1:0] diag_i,
  input  logic                      neq_i,
  output logic [lev_pkg::LEN_W-1:0] best_o
);

  logic [lev_pkg::LEN_W:0] up_c;
  logic [lev_pkg::LEN_W:0] left_c;
  logic [lev_pkg::LEN_W:0] sub_c;
  logic [lev_pkg::LEN_W:0] min_c;

  always_comb begin
    up_c   = {1'b0, up_i} + 1'b1;
    left_c = {1'b0, left_i} + 1'b1;
    sub_c  = {1'b0, diag_i} + {{lev_pkg::LEN_W{1'b0}}, neq_i};
    min_c  = up_c;
    if (left_c < min_c) begin
      min_c = left_c;
    end
    if (sub_c < min_c) begin
      min_c = sub_c;
    end
    best_o = min_c[lev_pkg::LEN_W-1:0];
  end

endmodule

// ===== design/lev_seq.sv =====
`timescale 1ns / 1ps

module lev_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lev_pkg::seq_ctrl_t         ctrl_i,
  output lev_pkg::seq_stat_t         stat_o,
  output logic [lev_pkg::ADDR_W-1:0] fw_addr_o,
  output logic [lev_pkg::ADDR_W-1:0] sw_addr_o,
  input  logic [lev_pkg::SYM_W-1:0]  fw_data_i,
  input  logic [lev_pkg::SYM_W-1:0]  sw_data_i
);

  lev_pkg::seq_state_e state_q, state_d;
  logic [lev_pkg::LEN_W-1:0] i_q, i_d;
  logic [lev_pkg::LEN_W-1:0] j_q, j_d;
  logic [lev_pkg::LEN_W-1:0] left_q, left_d;
  logic [lev_pkg::LEN_W-1:0] diag_q, diag_d;
  logic [lev_pkg::LEN_W-1:0] i_m1;
  logic [lev_pkg::LEN_W-1:0] j_m1;

  logic                      cr_we;
  logic [lev_pkg::LEN_W-1:0] cr_waddr;
  logic [lev_pkg::LEN_W-1:0] cr_wdata;
  logic [lev_pkg::LEN_W-1:0] cr_rdata;
  logic [lev_pkg::LEN_W-1:0] best;

  assign i_m1      = i_q - 1'b1;
  assign j_m1      = j_q - 1'b1;
  assign fw_addr_o = i_m1[lev_pkg::ADDR_W-1:0];
  assign sw_addr_o = j_m1[lev_pkg::ADDR_W-1:0];

  lev_ram #(
    .WIDTH(lev_pkg::LEN_W),
    .DEPTH(lev_pkg::ROW_D),
    .AW   (lev_pkg::LEN_W)
  ) u_cost_row (
    .clk_i  (clk_i),
    .we_i   (cr_we),
    .waddr_i(cr_waddr),
    .wdata_i(cr_wdata),
    .raddr_i(j_q),
    .rdata_o(cr_rdata)
  );

  lev_cell u_cell (
    .up_i  (cr_rdata),
    .left_i(left_q),
    .diag_i(diag_q),
    .neq_i (fw_data_i != sw_data_i),
    .best_o(best)
  );

  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    j_d           = j_q;
    left_d        = left_q;
    diag_d        = diag_q;
    cr_we         = 1'b0;
    cr_waddr      = j_q;
    cr_wdata      = j_q;
    stat_o.fin    = 1'b0;
    stat_o.result = best;
    unique case (state_q)
      lev_pkg::S_IDLE: begin
        if (ctrl_i.start) begin
          j_d     = '0;
          state_d = lev_pkg::S_INIT;
        end
      end
      lev_pkg::S_INIT: begin
        cr_we = 1'b1;
        if (j_q == ctrl_i.n2) begin
          if (ctrl_i.n1 == '0) begin
            stat_o.fin    = 1'b1;
            stat_o.result = ctrl_i.n2;
            state_d       = lev_pkg::S_IDLE;
          end else begin
            i_d     = {{(lev_pkg::LEN_W-1){1'b0}}, 1'b1};
            state_d = lev_pkg::S_ROW;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      lev_pkg::S_ROW: begin
        cr_we    = 1'b1;
        cr_waddr = '0;
        cr_wdata = i_q;
        diag_d   = i_m1;
        left_d   = i_q;
        if (ctrl_i.n2 == '0) begin
          if (i_q == ctrl_i.n1) begin
            stat_o.fin    = 1'b1;
            stat_o.result = i_q;
            state_d       = lev_pkg::S_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d     = {{(lev_pkg::LEN_W-1){1'b0}}, 1'b1};
          state_d = lev_pkg::S_RD;
        end
      end
      lev_pkg::S_RD: begin
        state_d = lev_pkg::S_CMP;
      end
      lev_pkg::S_CMP: begin
        cr_we    = 1'b1;
        cr_wdata = best;
        left_d   = best;
        diag_d   = cr_rdata;
        if (j_q == ctrl_i.n2) begin
          if (i_q == ctrl_i.n1) begin
            stat_o.fin = 1'b1;
            state_d    = lev_pkg::S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = lev_pkg::S_ROW;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = lev_pkg::S_RD;
        end
      end
      default: state_d = lev_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lev_pkg::S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    diag_q <= diag_d;
  end

endmodule

// ===== design/levenshtein_distance_core.sv =====
`timescale 1ns / 1ps
// Characters load one per cycle while idle; the completing transaction starts the DP run.
// The DP run steps the single min-of-three unit along the cost row, one entry per S_RD/S_CMP pair;
// the result is registered in res_q and then moved to the output register once that is free.
// A result may wait at the output while the next pair loads.
// Reset (async, active low) clears lengths, flags, sequencer and output valid; RAMs are not reset.
module levenshtein_distance_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lev_pkg::lev_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lev_pkg::lev_out_t out_data_o
);

  lev_pkg::top_state_e state_q, state_d;
  logic [lev_pkg::LEN_W-1:0] len1_q, len1_d;
  logic [lev_pkg::LEN_W-1:0] len2_q, len2_d;
  logic                      done1_q, done1_d;
  logic                      done2_q, done2_d;
  logic                      ovf_q, ovf_d;
  logic [lev_pkg::LEN_W-1:0] res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  lev_pkg::lev_out_t         out_q, out_d;

  logic                      accept;
  logic                      sel_done;
  logic [lev_pkg::LEN_W-1:0] sel_len;
  logic                      fw_we;
  logic                      sw_we;
  logic [lev_pkg::ADDR_W-1:0] waddr;
  logic [lev_pkg::SAT_W-1:0] res_ext;

  logic [lev_pkg::ADDR_W-1:0] fw_addr;
  logic [lev_pkg::ADDR_W-1:0] sw_addr;
  logic [lev_pkg::SYM_W-1:0]  fw_data;
  logic [lev_pkg::SYM_W-1:0]  sw_data;

  lev_pkg::seq_ctrl_t seq_ctrl;
  lev_pkg::seq_stat_t seq_stat;

  assign accept   = in_valid_i && !in_stall_o;
  assign sel_done = (in_data_i.mode == lev_pkg::MODE_SECOND) ? done2_q : done1_q;
  assign sel_len  = (in_data_i.mode == lev_pkg::MODE_SECOND) ? len2_q : len1_q;
  assign waddr    = sel_len[lev_pkg::ADDR_W-1:0];

  assign seq_ctrl.start = (state_q == lev_pkg::T_RUN);
  assign seq_ctrl.n1    = len1_q;
  assign seq_ctrl.n2    = len2_q;

  assign in_stall_o  = (state_q != lev_pkg::T_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    len1_d  = len1_q;
    len2_d  = len2_q;
    done1_d = done1_q;
    done2_d = done2_q;
    ovf_d   = ovf_q;
    fw_we   = 1'b0;
    sw_we   = 1'b0;
    if (accept && !sel_done) begin
      if (in_data_i.empty_req) begin
        if (in_data_i.mode == lev_pkg::MODE_SECOND) begin
          len2_d  = '0;
          done2_d = 1'b1;
        end else begin
          len1_d  = '0;
          done1_d = 1'b1;
        end
      end else begin
        if (sel_len < lev_pkg::LEN_W'(lev_pkg::MAX_LEN)) begin
          if (in_data_i.mode == lev_pkg::MODE_SECOND) begin
            sw_we  = 1'b1;
            len2_d = len2_q + 1'b1;
          end else begin
            fw_we  = 1'b1;
            len1_d = len1_q + 1'b1;
          end
        end else begin
          ovf_d = 1'b1;
        end
        if (in_data_i.last) begin
          if (in_data_i.mode == lev_pkg::MODE_SECOND) begin
            done2_d = 1'b1;
          end else begin
            done1_d = 1'b1;
          end
        end
      end
    end

    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    res_ext     = lev_pkg::SAT_W'(res_q);
    unique case (state_q)
      lev_pkg::T_IDLE: begin
        if (done1_d && done2_d) begin
          state_d = lev_pkg::T_RUN;
        end
      end
      lev_pkg::T_RUN: begin
        if (seq_stat.fin) begin
          res_d   = seq_stat.result;
          state_d = lev_pkg::T_DONE;
        end
      end
      lev_pkg::T_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (res_ext > lev_pkg::SAT_W'(lev_pkg::DIST_MAX)) begin
            out_d.distance = lev_pkg::DIST_MAX;
          end else begin
            out_d.distance = res_ext[lev_pkg::DIST_W-1:0];
          end
          out_d.too_long = ovf_q;
          len1_d  = '0;
          len2_d  = '0;
          done1_d = 1'b0;
          done2_d = 1'b0;
          ovf_d   = 1'b0;
          state_d = lev_pkg::T_IDLE;
        end
      end
      default: state_d = lev_pkg::T_IDLE;
    endcase
  end

  lev_ram #(
    .WIDTH(lev_pkg::SYM_W),
    .DEPTH(lev_pkg::MAX_LEN),
    .AW   (lev_pkg::ADDR_W)
  ) u_first_word (
    .clk_i  (clk_i),
    .we_i   (fw_we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.symbol),
    .raddr_i(fw_addr),
    .rdata_o(fw_data)
  );

  lev_ram #(
    .WIDTH(lev_pkg::SYM_W),
    .DEPTH(lev_pkg::MAX_LEN),
    .AW   (lev_pkg::ADDR_W)
  ) u_second_word (
    .clk_i  (clk_i),
    .we_i   (sw_we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.symbol),
    .raddr_i(sw_addr),
    .rdata_o(sw_data)
  );

  lev_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (seq_ctrl),
    .stat_o   (seq_stat),
    .fw_addr_o(fw_addr),
    .sw_addr_o(sw_addr),
    .fw_data_i(fw_data),
    .sw_data_i(sw_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lev_pkg::T_IDLE;
      len1_q      <= '0;
      len2_q      <= '0;
      done1_q     <= 1'b0;
      done2_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len1_q      <= len1_d;
      len2_q      <= len2_d;
      done1_q     <= done1_d;
      done2_q     <= done2_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

// ===== tb/levenshtein_distance_core_test.sv =====
`timescale 1ns / 1ps

module levenshtein_distance_core_test;

  localparam int ITEM_TARGET  = 1350;
  localparam int LONG_HOLD    = 3000;
  localparam int DRAIN_CYCLES = 2500;

  typedef lev_pkg::lev_in_t item_q_t[$];

  typedef struct {
    lev_pkg::lev_in_t  item;
    bit                typed;
    lev_pkg::lev_out_t result;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  lev_pkg::lev_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lev_pkg::lev_out_t out_data;

  // model state
  logic [lev_pkg::SYM_W-1:0] word_mem [2][lev_pkg::MAX_LEN];
  int               word_len [2] = '{0, 0};
  bit               word_done [2] = '{0, 0};
  bit               overflow_seen = 1'b0;

  lev_pkg::lev_out_t pending_results[$];
  dir_row_t directed_rows[$];
  int       mismatch_count = 0;
  int       items_loaded   = 0;
  bit       no_idle        = 1'b0;
  bit       hold_request   = 1'b0;

  levenshtein_distance_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int calc_distance();
    int row [lev_pkg::MAX_LEN+1];
    int n1, n2, diag, up, best, cand;
    n1 = word_len[0];
    n2 = word_len[1];
    for (int j = 0; j <= n2; j++) row[j] = j;
    for (int i = 1; i <= n1; i++) begin
      diag   = row[0];
      row[0] = i;
      for (int j = 1; j <= n2; j++) begin
        up   = row[j];
        best = up + 1;
        cand = row[j-1] + 1;
        if (cand < best) best = cand;
        cand = diag + ((word_mem[0][i-1] != word_mem[1][j-1]) ? 1 : 0);
        if (cand < best) best = cand;
        diag   = up;
        row[j] = best;
      end
    end
    return row[n2];
  endfunction

  function automatic void load_symbol(input lev_pkg::lev_in_t it, output bit fired,
                                      output lev_pkg::lev_out_t res);
    int idx;
    int d;
    fired = 1'b0;
    res   = '0;
    idx   = (it.mode == lev_pkg::MODE_SECOND) ? 1 : 0;
    if (!word_done[idx]) begin
      if (it.empty_req) begin
        word_len[idx]  = 0;
        word_done[idx] = 1'b1;
      end else begin
        if (word_len[idx] < lev_pkg::MAX_LEN) begin
          word_mem[idx][word_len[idx]] = it.symbol;
          word_len[idx]++;
        end else begin
          overflow_seen = 1'b1;
        end
        if (it.last) word_done[idx] = 1'b1;
      end
    end
    if (word_done[0] && word_done[1]) begin
      d = calc_distance();
      if (d > int'(lev_pkg::DIST_MAX)) d = int'(lev_pkg::DIST_MAX);
      res.distance = d[lev_pkg::DIST_W-1:0];
      res.too_long = overflow_seen;
      fired        = 1'b1;
      word_len     = '{0, 0};
      word_done    = '{0, 0};
      overflow_seen = 1'b0;
    end
  endfunction

  task automatic drive_item(input lev_pkg::lev_in_t it, input bit typed,
                            input lev_pkg::lev_out_t typed_res);
    int                gap;
    bit                fired;
    lev_pkg::lev_out_t res;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    load_symbol(it, fired, res);
    if (fired) pending_results.insert(pending_results.size(), typed ? typed_res : res);
  endtask

  function automatic void add_row(logic md, logic [lev_pkg::SYM_W-1:0] sym, logic lst,
                                  logic emp, bit chk = 1'b0,
                                  logic [lev_pkg::DIST_W-1:0] want_dist = '0);
    dir_row_t row;
    row.item            = '{mode: md, symbol: sym, last: lst, empty_req: emp};
    row.typed           = chk;
    row.result.distance = want_dist;
    row.result.too_long = 1'b0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic logic [lev_pkg::SYM_W-1:0] rand_symbol(bit narrow);
    return narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic item_q_t build_word(logic md);
    item_q_t          q;
    lev_pkg::lev_in_t it;
    int               n, r, k;
    bit               narrow;
    r = $urandom_range(0, 99);
    if (r < 75)      n = $urandom_range(0, 6);
    else if (r < 92) n = $urandom_range(0, lev_pkg::MAX_LEN);
    else if (r < 97) n = lev_pkg::MAX_LEN;
    else             n = $urandom_range(lev_pkg::MAX_LEN + 1, lev_pkg::MAX_LEN + 3);
    narrow = ($urandom_range(0, 9) < 7);
    it.mode = md;
    // aborted word: partial load, then cleared by an empty request
    if (n > 0 && $urandom_range(0, 19) == 0) begin
      k = $urandom_range(1, n);
      for (int i = 0; i < k; i++) begin
        it.symbol    = rand_symbol(narrow);
        it.last      = 1'b0;
        it.empty_req = 1'b0;
        q.insert(q.size(), it);
      end
      n = 0;
    end
    if (n == 0) begin
      it.symbol    = 8'($urandom);
      it.last      = 1'($urandom);
      it.empty_req = 1'b1;
      q.insert(q.size(), it);
    end else begin
      for (int i = 0; i < n; i++) begin
        it.symbol    = rand_symbol(narrow);
        it.last      = (i == n - 1);
        it.empty_req = 1'b0;
        q.insert(q.size(), it);
      end
    end
    return q;
  endfunction

  task automatic gen_pair();
    item_q_t          q0, q1;
    lev_pkg::lev_in_t noise;
    int               style, pick;
    q0    = build_word(lev_pkg::MODE_FIRST);
    q1    = build_word(lev_pkg::MODE_SECOND);
    style = $urandom_range(0, 2);
    while (q0.size() + q1.size() > 0) begin
      // transaction for a word already complete; ignored
      if ((q0.size() == 0) != (q1.size() == 0) && $urandom_range(0, 9) == 0) begin
        noise.mode      = (q0.size() == 0) ? lev_pkg::MODE_FIRST : lev_pkg::MODE_SECOND;
        noise.symbol    = 8'($urandom);
        noise.last      = 1'($urandom);
        noise.empty_req = 1'($urandom);
        drive_item(noise, 1'b0, '0);
        items_loaded++;
      end
      if (q0.size() != 0 && q1.size() != 0)
        pick = (style == 2) ? $urandom_range(0, 1) : style;
      else
        pick = (q0.size() != 0) ? 0 : 1;
      if (pick == 0) drive_item(q0.pop_front(), 1'b0, '0);
      else           drive_item(q1.pop_front(), 1'b0, '0);
      items_loaded++;
    end
  endtask

  always @(posedge clk) begin
    lev_pkg::lev_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual distance %0d too_long %0b",
                 $time, out_data.distance, out_data.too_long);
      end else begin
        want = pending_results.pop_front();
        if (!want.too_long && out_data.distance !== want.distance) begin
          mismatch_count++;
          $display("%0t: distance mismatch: expected %0d, actual %0d",
                   $time, want.distance, out_data.distance);
        end
        if (out_data.too_long !== want.too_long) begin
          mismatch_count++;
          $display("%0t: too_long mismatch: expected %0b, actual %0b",
                   $time, want.too_long, out_data.too_long);
        end
      end
    end
  end

  initial begin
    int gap;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL levenshtein_distance_core");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    add_row(lev_pkg::MODE_FIRST,  8'h00, 1'b0, 1'b1);
    add_row(lev_pkg::MODE_SECOND, 8'h00, 1'b0, 1'b1, 1'b1, 6'd0);
    add_row(lev_pkg::MODE_SECOND, 8'hff, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_FIRST,  8'h00, 1'b0, 1'b1, 1'b1, 6'd1);
    add_row(lev_pkg::MODE_FIRST,  8'h00, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_SECOND, 8'hff, 1'b1, 1'b0, 1'b1, 6'd1);
    add_row(lev_pkg::MODE_FIRST,  8'hff, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_SECOND, 8'hff, 1'b1, 1'b0, 1'b1, 6'd0);
    add_row(lev_pkg::MODE_FIRST,  8'h61, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_FIRST,  8'h62, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_SECOND, 8'h61, 1'b1, 1'b0, 1'b1, 6'd0);
    add_row(lev_pkg::MODE_SECOND, 8'hff, 1'b1, 1'b1);
    add_row(lev_pkg::MODE_FIRST,  8'h78, 1'b0, 1'b0);
    add_row(lev_pkg::MODE_FIRST,  8'h79, 1'b0, 1'b0);
    add_row(lev_pkg::MODE_FIRST,  8'h00, 1'b1, 1'b1, 1'b1, 6'd0);
    add_row(lev_pkg::MODE_FIRST,  8'h61, 1'b0, 1'b0);
    add_row(lev_pkg::MODE_FIRST,  8'h62, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_SECOND, 8'h62, 1'b0, 1'b0);
    add_row(lev_pkg::MODE_SECOND, 8'h61, 1'b1, 1'b0);
    add_row(lev_pkg::MODE_SECOND, 8'h55, 1'b0, 1'b1);
    add_row(lev_pkg::MODE_FIRST,  8'h80, 1'b0, 1'b0);
    add_row(lev_pkg::MODE_FIRST,  8'h7f, 1'b1, 1'b0);

    foreach (directed_rows[k])
      drive_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].result);

    hold_request = 1'b1;
    while (items_loaded < ITEM_TARGET) begin
      no_idle = (items_loaded >= 500 && items_loaded < 650);
      gen_pair();
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS levenshtein_distance_core");
    end else begin
      $display("FAIL levenshtein_distance_core");
    end
    $finish;
  end

endmodule
